>>> rtl/core/block_diagonal_inertia_counter_unit_macros.svh
// Assertion macros used by the back part of the inertia counter RTL.
// Each macro expects signals named clock and reset in the using module.
`ifndef BLOCK_DIAGONAL_INERTIA_COUNTER_UNIT_MACROS_SVH
`define BLOCK_DIAGONAL_INERTIA_COUNTER_UNIT_MACROS_SVH

// A condition that must hold at every clock edge out of reset.
`define BDIC_CHECK(lbl, cond, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (cond)) else $error(msg);

// A condition that must hold in the cycle after a trigger.
`define BDIC_CHECK_NEXT(lbl, trig, cond, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (trig) |=> (cond)) \
      else $error(msg);

// A condition that must hold in the same cycle as a trigger.
`define BDIC_CHECK_NOW(lbl, trig, cond, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (trig) |-> (cond)) \
      else $error(msg);

`endif

>>> rtl/core/bdic_pkg.sv
// Shared types and constants of the block-diagonal inertia counter.
// No dependencies; the front, queue, back and top files import it.
`default_nettype none

package bdic_pkg;

   // Default configuration of the unit.
   localparam int BDIC_MAX_ORDER   = 65536;
   localparam int BDIC_VALUE_WIDTH = 32;

   // Fixed field widths of the channels.
   localparam int BDIC_FIELD_W = 32;
   localparam int BDIC_COUNT_W = 17;
   localparam int BDIC_COUNT_LIMIT = (1 << BDIC_COUNT_W) - 1;

   // Depth of the queue between the front and back parts.
   localparam int BDIC_QUEUE_DEPTH = 2;

   // One row as it arrives.
   typedef struct packed {
      logic signed [BDIC_FIELD_W-1:0] diag_real;
      logic signed [BDIC_FIELD_W-1:0] coupling_re;
      logic signed [BDIC_FIELD_W-1:0] coupling_im;
      logic                           two_by_two;
      logic                           last;
   } bdic_req_type;

   // The counts sent out on the last row.
   typedef struct packed {
      logic [BDIC_COUNT_W-1:0] pos_count;
      logic [BDIC_COUNT_W-1:0] neg_count;
      logic [BDIC_COUNT_W-1:0] zero_count;
   } bdic_rsp_type;

   // Classified row: how much each counter grows, and whether to report.
   typedef struct packed {
      logic       last;
      logic [1:0] pos_inc;
      logic [1:0] neg_inc;
      logic [1:0] zero_inc;
   } bdic_inc_type;

endpackage

`default_nettype wire

>>> rtl/core/bdic_front.sv
// Front part of the inertia counter: accepts rows, tracks 2-by-2 pairs and
// classifies each row into counter increments. Depends on bdic_pkg.
`default_nettype none

module bdic_front import bdic_pkg::*; #(
   parameter int VALUE_WIDTH = BDIC_VALUE_WIDTH
) (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_valid,
   output logic              req_ready,
   input  wire bdic_req_type req_data,
   output logic              push_valid,
   input  wire logic         push_ready,
   output bdic_inc_type      push_data
);

   localparam int PW = 2 * VALUE_WIDTH;

   // Row held between the accept register and the queue.
   typedef struct packed {
      logic                 last;
      logic                 close;
      logic                 czero;
      logic                 a_pos;
      logic                 a_neg;
      logic                 d_pos;
      logic                 d_neg;
      logic signed [PW-1:0] prod;
   } stage_type;

   logic                          accept;
   logic                          is_start;
   logic signed [VALUE_WIDTH-1:0] d_s;
   logic signed [VALUE_WIDTH-1:0] re_s;
   logic signed [VALUE_WIDTH-1:0] im_s;
   logic                          d_neg;
   logic                          d_pos;
   logic signed [PW-1:0]          prod_in;
   logic signed [PW-1:0]          sq_re_s;
   logic signed [PW-1:0]          sq_im_s;
   stage_type                     stage_in;

   logic                          s1_valid_ff;
   logic                          s1_valid_in;
   stage_type                     s1_ff;
   logic                          pair_open_ff;
   logic                          pair_open_in;
   logic signed [VALUE_WIDTH-1:0] held_diag_ff;
   logic                          held_pos_ff;
   logic                          held_neg_ff;
   logic                          held_czero_ff;
   logic [PW-1:0]                 sq_re_ff;
   logic [PW-1:0]                 sq_im_ff;

   logic [PW-1:0]                 csq;
   logic                          prod_nonpos;
   logic                          prod_lt;
   logic                          prod_gt;
   bdic_inc_type                  inc;

   // A row enters when the stage is empty or moves on in the same cycle.
   assign req_ready = !s1_valid_ff || push_ready;
   assign accept    = req_valid && req_ready;

   // Value fields are taken as their low VALUE_WIDTH bits, signed.
   assign d_s  = req_data.diag_real[VALUE_WIDTH-1:0];
   assign re_s = req_data.coupling_re[VALUE_WIDTH-1:0];
   assign im_s = req_data.coupling_im[VALUE_WIDTH-1:0];

   // A pair opens on a flagged row that is not the last one; any row that
   // arrives while a pair is open closes it.
   assign is_start = !pair_open_ff && req_data.two_by_two && !req_data.last;

   assign d_neg = d_s[VALUE_WIDTH-1];
   assign d_pos = !d_neg && (d_s != '0);

   // One multiplier for a*c on the closing row, two for the coupling squares.
   assign prod_in = held_diag_ff * d_s;
   assign sq_re_s = re_s * re_s;
   assign sq_im_s = im_s * im_s;

   always_comb begin
      stage_in.last  = req_data.last;
      stage_in.close = pair_open_ff;
      stage_in.czero = held_czero_ff;
      stage_in.a_pos = held_pos_ff;
      stage_in.a_neg = held_neg_ff;
      stage_in.d_pos = d_pos;
      stage_in.d_neg = d_neg;
      stage_in.prod  = prod_in;
   end

   // Pair-opening rows count nothing, so they never occupy the stage.
   always_comb begin
      if (accept && !is_start) begin
         s1_valid_in = 1'b1;
      end else if (push_valid && push_ready) begin
         s1_valid_in = 1'b0;
      end else begin
         s1_valid_in = s1_valid_ff;
      end
   end

   assign pair_open_in = accept ? is_start : pair_open_ff;

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         pair_open_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         pair_open_ff <= pair_open_in;
      end
   end

   // Stage payload and the first row of an open pair.
   always_ff @(posedge clock) begin
      if (accept) begin
         s1_ff <= stage_in;
      end
      if (accept && is_start) begin
         held_diag_ff  <= d_s;
         held_pos_ff   <= d_pos;
         held_neg_ff   <= d_neg;
         held_czero_ff <= (re_s == '0) && (im_s == '0);
         sq_re_ff      <= $unsigned(sq_re_s);
         sq_im_ff      <= $unsigned(sq_im_s);
      end
   end

   // The squares stay put while a closing row waits here, since a new pair
   // can only open when this stage moves on. The sum cannot carry out: each
   // square is at most 2^(PW-2).
   assign csq         = sq_re_ff + sq_im_ff;
   assign prod_nonpos = s1_ff.prod[PW-1] || (s1_ff.prod == '0);
   assign prod_lt     = $unsigned(s1_ff.prod) < csq;
   assign prod_gt     = $unsigned(s1_ff.prod) > csq;

   // Turn the row into counter increments.
   always_comb begin
      inc      = '0;
      inc.last = s1_ff.last;
      if (!s1_ff.close) begin
         inc.pos_inc  = {1'b0, s1_ff.d_pos};
         inc.neg_inc  = {1'b0, s1_ff.d_neg};
         inc.zero_inc = {1'b0, !s1_ff.d_pos && !s1_ff.d_neg};
      end else if (s1_ff.czero) begin
         // Uncoupled pair: each diagonal counts by its own sign.
         inc.pos_inc  = {1'b0, s1_ff.a_pos} + {1'b0, s1_ff.d_pos};
         inc.neg_inc  = {1'b0, s1_ff.a_neg} + {1'b0, s1_ff.d_neg};
         inc.zero_inc = {1'b0, !s1_ff.a_pos && !s1_ff.a_neg}
                      + {1'b0, !s1_ff.d_pos && !s1_ff.d_neg};
      end else begin
         // Coupled pair: sign of a*c - |b|^2, and the second row is positive.
         inc.neg_inc  = {1'b0, prod_nonpos || prod_lt};
         inc.pos_inc  = 2'd1 + {1'b0, !prod_nonpos && prod_gt};
         inc.zero_inc = {1'b0, !prod_nonpos && !prod_lt && !prod_gt};
      end
   end

   assign push_valid = s1_valid_ff;
   assign push_data  = inc;

endmodule

`default_nettype wire

>>> rtl/core/bdic_queue.sv
// Short register queue between the front and back parts.
// Depends on bdic_pkg for the entry type and depth.
`default_nettype none

module bdic_queue import bdic_pkg::*; (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         in_valid,
   output logic              in_ready,
   input  wire bdic_inc_type in_data,
   output logic              out_valid,
   input  wire logic         out_ready,
   output bdic_inc_type      out_data
);

   localparam int PTR_W = (BDIC_QUEUE_DEPTH > 1) ? $clog2(BDIC_QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(BDIC_QUEUE_DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST_SLOT = PTR_W'(BDIC_QUEUE_DEPTH - 1);
   localparam logic [CNT_W-1:0] FULL_CNT  = CNT_W'(BDIC_QUEUE_DEPTH);

   bdic_inc_type      slot_ff [BDIC_QUEUE_DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff;
   logic [PTR_W-1:0]  wr_ptr_in;
   logic [PTR_W-1:0]  rd_ptr_ff;
   logic [PTR_W-1:0]  rd_ptr_in;
   logic [CNT_W-1:0]  fill_ff;
   logic [CNT_W-1:0]  fill_in;
   logic              do_push;
   logic              do_pop;

   assign in_ready  = (fill_ff != FULL_CNT);
   assign out_valid = (fill_ff != '0);
   assign out_data  = slot_ff[rd_ptr_ff];

   assign do_push = in_valid && in_ready;
   assign do_pop  = out_valid && out_ready;

   // Pointer and fill bookkeeping.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      fill_in   = fill_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_SLOT) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_SLOT) ? '0 : rd_ptr_ff + 1'b1;
      end
      case ({do_push, do_pop})
         2'b10:   fill_in = fill_ff + 1'b1;
         2'b01:   fill_in = fill_ff - 1'b1;
         default: fill_in = fill_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   // Entry storage.
   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= in_data;
      end
   end

endmodule

`default_nettype wire

>>> rtl/core/bdic_back.sv
// Back part of the inertia counter: saturating counters and the result
// register. Depends on bdic_pkg and the assertion macro header.
`default_nettype none
`include "block_diagonal_inertia_counter_unit_macros.svh"

module bdic_back import bdic_pkg::*; #(
   parameter int MAX_ORDER = BDIC_MAX_ORDER
) (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         pop_valid,
   output logic              pop_ready,
   input  wire bdic_inc_type pop_data,
   output logic              rsp_valid,
   input  wire logic         rsp_ready,
   output bdic_rsp_type      rsp_data
);

   localparam int CAP_INT = (MAX_ORDER < BDIC_COUNT_LIMIT) ? MAX_ORDER : BDIC_COUNT_LIMIT;
   localparam logic [BDIC_COUNT_W-1:0] COUNT_CAP = BDIC_COUNT_W'(CAP_INT);

   logic [BDIC_COUNT_W-1:0] pos_total_ff;
   logic [BDIC_COUNT_W-1:0] neg_total_ff;
   logic [BDIC_COUNT_W-1:0] zero_total_ff;
   logic [BDIC_COUNT_W-1:0] pos_next;
   logic [BDIC_COUNT_W-1:0] neg_next;
   logic [BDIC_COUNT_W-1:0] zero_next;
   logic                    rsp_valid_ff;
   logic                    rsp_valid_in;
   bdic_rsp_type            rsp_data_ff;
   logic                    do_pop;
   logic                    do_report;
   logic                    counts_in_cap;
   logic                    counts_clear;

   // Add up to two and stop at the cap; the count never starts above it.
   function automatic logic [BDIC_COUNT_W-1:0] sat_add(
      input logic [BDIC_COUNT_W-1:0] cnt,
      input logic [1:0]              inc
   );
      logic [BDIC_COUNT_W:0] sum;
      sum = (BDIC_COUNT_W+1)'(cnt) + (BDIC_COUNT_W+1)'(inc);
      if (sum > (BDIC_COUNT_W+1)'(COUNT_CAP)) begin
         return COUNT_CAP;
      end
      return sum[BDIC_COUNT_W-1:0];
   endfunction

   // A reporting beat waits only while an untaken result sits in the register.
   assign pop_ready = !pop_data.last || !rsp_valid_ff || rsp_ready;
   assign do_pop    = pop_valid && pop_ready;
   assign do_report = do_pop && pop_data.last;

   assign pos_next  = sat_add(pos_total_ff, pop_data.pos_inc);
   assign neg_next  = sat_add(neg_total_ff, pop_data.neg_inc);
   assign zero_next = sat_add(zero_total_ff, pop_data.zero_inc);

   // Running counts; they restart from zero after each report.
   always_ff @(posedge clock) begin
      if (reset) begin
         pos_total_ff  <= '0;
         neg_total_ff  <= '0;
         zero_total_ff <= '0;
      end else if (do_report) begin
         pos_total_ff  <= '0;
         neg_total_ff  <= '0;
         zero_total_ff <= '0;
      end else if (do_pop) begin
         pos_total_ff  <= pos_next;
         neg_total_ff  <= neg_next;
         zero_total_ff <= zero_next;
      end
   end

   // Result register.
   always_comb begin
      if (do_report) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_report) begin
         rsp_data_ff.pos_count  <= pos_next;
         rsp_data_ff.neg_count  <= neg_next;
         rsp_data_ff.zero_count <= zero_next;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // Summary flags for the checks below.
   assign counts_in_cap = (pos_total_ff <= COUNT_CAP) && (neg_total_ff <= COUNT_CAP)
                       && (zero_total_ff <= COUNT_CAP);
   assign counts_clear  = (pos_total_ff == '0) && (neg_total_ff == '0)
                       && (zero_total_ff == '0);

   // Counters never pass the cap.
   `BDIC_CHECK(a_count_cap, counts_in_cap, "count above cap")
   // A report leaves all counters at zero.
   `BDIC_CHECK_NEXT(a_clear_after_report, do_report, counts_clear, "counts not cleared")
   // A report never overwrites a result that is still waiting.
   `BDIC_CHECK_NOW(a_no_overwrite, do_report, !rsp_valid_ff || rsp_ready, "result overwritten")

endmodule

`default_nettype wire

>>> rtl/core/block_diagonal_inertia_counter_unit.sv
// Top level of the block-diagonal inertia counter.
// Depends on bdic_pkg, bdic_front, bdic_queue and bdic_back.
//
//   Channel  Dir  Handshake              Payload        Beat
//   req_     in   req_valid/req_ready    bdic_req_type  one matrix row
//   rsp_     out  rsp_valid/rsp_ready    bdic_rsp_type  counts of one matrix
//
// One row is taken every cycle while the queue has room; the rate is set by
// the front register, which holds the a*c product and closes the pair
// compare before the queue. The last row's counts pass the front register and
// the queue before they reach the result register that drives rsp_valid.
// Reset is synchronous and clears the pair state, queue and counters.
// A waiting result holds the next last row at the queue head; up to four
// more rows behind it, pair openers included, are taken before req_ready drops.
`default_nettype none

module block_diagonal_inertia_counter_unit import bdic_pkg::*; #(
   parameter int MAX_ORDER   = BDIC_MAX_ORDER,
   parameter int VALUE_WIDTH = BDIC_VALUE_WIDTH
) (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_valid,
   output logic              req_ready,
   input  wire bdic_req_type req_data,
   output logic              rsp_valid,
   input  wire logic         rsp_ready,
   output bdic_rsp_type      rsp_data
);

   logic         push_valid;
   logic         push_ready;
   bdic_inc_type push_data;
   logic         pop_valid;
   logic         pop_ready;
   bdic_inc_type pop_data;

   // Row intake and classification.
   bdic_front #(
      .VALUE_WIDTH(VALUE_WIDTH)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_data   (req_data),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  (push_data)
   );

   // Decoupling queue.
   bdic_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (push_valid),
      .in_ready  (push_ready),
      .in_data   (push_data),
      .out_valid (pop_valid),
      .out_ready (pop_ready),
      .out_data  (pop_data)
   );

   // Counting and result output.
   bdic_back #(
      .MAX_ORDER(MAX_ORDER)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .pop_valid (pop_valid),
      .pop_ready (pop_ready),
      .pop_data  (pop_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule

`default_nettype wire

>>> bench/tb_block_diagonal_inertia_counter_unit.sv
// Self-checking bench for the block-diagonal inertia counter: streams matrix rows
// through the req_ channel and checks every count beat on the rsp_ channel.
// Depends on bdic_pkg and block_diagonal_inertia_counter_unit.
module tb_block_diagonal_inertia_counter_unit;
   import bdic_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   typedef longint unsigned u64_type;

   localparam int          ROW_BUDGET    = 330;
   localparam int          LONG_ROWS     = 150;
   localparam int          STALL_LIMIT   = 2000;
   localparam int unsigned COUNT_CAP     =
      (BDIC_MAX_ORDER < 131071) ? BDIC_MAX_ORDER : 131071;
   localparam logic [31:0] VAL_MAX       = 32'h7FFF_FFFF;
   localparam logic [31:0] VAL_MIN       = 32'h8000_0000;
   localparam logic [31:0] ONE_Q16       = 32'h0001_0000;

   logic         clock     = 1'b0;
   logic         reset     = 1'b1;
   logic         req_valid = 1'b0;
   logic         req_ready;
   bdic_req_type req_data  = '0;
   logic         rsp_valid;
   logic         rsp_ready = 1'b0;
   bdic_rsp_type rsp_data;

   bdic_req_type row_queue[$];
   bdic_rsp_type expected_counts[$];
   int           send_idle_pct  = 0;
   int           recv_stall_pct = 0;
   int           mismatches     = 0;
   int           idle_cycles    = 0;

   // Inertia state as the block should hold it.
   bit              pair_open;
   longint          held_diag;
   longint unsigned held_coupling_sq;
   int unsigned     pos_total, neg_total, zero_total;

   block_diagonal_inertia_counter_unit dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   always #5 clock = ~clock;

   // Low VALUE_WIDTH bits of a field, sign-extended.
   function automatic longint fixed_value(logic [31:0] raw);
      logic signed [31:0] s;
      s = raw << (32 - BDIC_VALUE_WIDTH);
      return longint'(s >>> (32 - BDIC_VALUE_WIDTH));
   endfunction

   function automatic int unsigned bumped(int unsigned c);
      return (c < COUNT_CAP) ? c + 1 : c;
   endfunction

   function void count_by_sign(longint v);
      if (v > 0)
         pos_total = bumped(pos_total);
      else if (v < 0)
         neg_total = bumped(neg_total);
      else
         zero_total = bumped(zero_total);
   endfunction

   // Fold one accepted row into the running inertia; a last row yields counts.
   function void tally_row(bdic_req_type row);
      longint       d, re, im, prod;
      bdic_rsp_type counts;
      d  = fixed_value(row.diag_real);
      re = fixed_value(row.coupling_re);
      im = fixed_value(row.coupling_im);
      if (pair_open) begin
         if (held_coupling_sq == 0) begin
            count_by_sign(held_diag);
            count_by_sign(d);
         end else begin
            // Sign of the 2-by-2 determinant a*c - |b|^2, then one positive.
            prod = held_diag * d;
            if (prod <= 0 || u64_type'(prod) < held_coupling_sq)
               neg_total = bumped(neg_total);
            else if (u64_type'(prod) > held_coupling_sq)
               pos_total = bumped(pos_total);
            else
               zero_total = bumped(zero_total);
            pos_total = bumped(pos_total);
         end
         pair_open = 1'b0;
      end else if (row.two_by_two && !row.last) begin
         held_diag        = d;
         held_coupling_sq = u64_type'(re * re) + u64_type'(im * im);
         pair_open        = 1'b1;
      end else begin
         count_by_sign(d);
      end
      if (row.last) begin
         counts.pos_count  = pos_total[BDIC_COUNT_W-1:0];
         counts.neg_count  = neg_total[BDIC_COUNT_W-1:0];
         counts.zero_count = zero_total[BDIC_COUNT_W-1:0];
         expected_counts.push_back(counts);
         pos_total  = 0;
         neg_total  = 0;
         zero_total = 0;
         pair_open  = 1'b0;
      end
   endfunction

   function void check_count(string what, logic [BDIC_COUNT_W-1:0] want,
                             logic [BDIC_COUNT_W-1:0] got);
      if (got !== want) begin
         $display("%0t ns: %s expected %0d, got %0d", $time, what, want, got);
         mismatches++;
      end
   endfunction

   // Driver: offers the next queued row once the current beat is taken.
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_ready) begin
         if (row_queue.size() > 0 && $urandom_range(99, 0) >= send_idle_pct) begin
            req_valid <= 1'b1;
            req_data  <= row_queue.pop_front();
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Monitor: predicts on every row beat and checks every count beat.
   always @(posedge clock) begin : monitor
      bdic_rsp_type want;
      if (reset) begin
         rsp_ready        <= 1'b0;
         pair_open        = 1'b0;
         held_diag        = 0;
         held_coupling_sq = 0;
         pos_total        = 0;
         neg_total        = 0;
         zero_total       = 0;
      end else begin
         rsp_ready <= ($urandom_range(99, 0) >= recv_stall_pct);
         if (req_valid && req_ready)
            tally_row(req_data);
         if (rsp_valid && rsp_ready) begin
            if (expected_counts.size() == 0) begin
               $display("%0t ns: count beat with none expected, got %0d/%0d/%0d",
                        $time, rsp_data.pos_count, rsp_data.neg_count,
                        rsp_data.zero_count);
               mismatches++;
            end else begin
               want = expected_counts.pop_front();
               check_count("pos_count", want.pos_count, rsp_data.pos_count);
               check_count("neg_count", want.neg_count, rsp_data.neg_count);
               check_count("zero_count", want.zero_count, rsp_data.zero_count);
            end
         end
      end
   end

   // Watchdog: too long without any beat on either channel ends the run.
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
         $display("[block_diagonal_inertia_counter_unit] ERROR");
         $finish;
      end
   end

   task automatic add_row(logic [31:0] d, logic [31:0] re, logic [31:0] im,
                          logic pair, logic last);
      bdic_req_type row;
      row.diag_real   = d;
      row.coupling_re = re;
      row.coupling_im = im;
      row.two_by_two  = pair;
      row.last        = last;
      row_queue.push_back(row);
   endtask

   // Mix of extremes, zero, small magnitudes and full-range words.
   function automatic logic [31:0] any_value();
      case ($urandom_range(7, 0))
         0:       return '0;
         1:       return VAL_MAX;
         2:       return VAL_MIN;
         3:       return $urandom_range(255, 0);
         4:       return -$urandom_range(255, 1);
         default: return $urandom;
      endcase
   endfunction

   // One matrix of mostly well-formed 1-by-1 rows and pairs; some are noise.
   task automatic add_random_matrix(output int added);
      int          rows, i;
      bit          noise;
      logic [31:0] a, c, re, im;
      rows  = ($urandom_range(9, 0) == 0) ? $urandom_range(40, 1) : $urandom_range(8, 1);
      noise = ($urandom_range(9, 0) == 0);
      i     = 0;
      while (i < rows) begin
         if (noise) begin
            add_row(any_value(), any_value(), any_value(), 1'($urandom_range(1, 0)),
                    (i == rows - 1) || ($urandom_range(7, 0) == 0));
            i++;
         end else if ($urandom_range(9, 0) < 4) begin
            add_row(any_value(), any_value(), any_value(), 1'b0, i == rows - 1);
            i++;
         end else if (i == rows - 1) begin
            // A pair that would start on the last row counts as one row.
            add_row(any_value(), any_value(), any_value(), 1'b1, 1'b1);
            i++;
         end else begin
            a  = any_value();
            c  = any_value();
            re = any_value();
            im = any_value();
            case ($urandom_range(3, 0))
               0: begin
                  re = '0;
                  im = '0;
               end
               1: begin
                  // Determinant exactly zero, or with c one above a.
                  im = '0;
                  a  = re;
                  c  = re + $urandom_range(1, 0);
               end
               default: ;
            endcase
            add_row(a, re, im, 1'b1, 1'b0);
            add_row(c, any_value(), any_value(), $urandom_range(7, 0) != 0,
                    i + 1 == rows - 1);
            i += 2;
         end
      end
      added = rows;
   endtask

   // Hold off until every row is taken and every count beat has arrived.
   task automatic wait_drained();
      do
         @(negedge clock);
      while (row_queue.size() != 0 || req_valid || expected_counts.size() != 0);
   endtask

   task automatic run_random_phase(int send_pct, int recv_pct);
      int total, n;
      send_idle_pct  = send_pct;
      recv_stall_pct = recv_pct;
      total          = 0;
      while (total < ROW_BUDGET) begin
         add_random_matrix(n);
         total += n;
      end
      wait_drained();
   endtask

   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed rows: extremes, each sign, every pair case.
      add_row(VAL_MAX, '0, '0, 1'b0, 1'b0);
      add_row(VAL_MIN, '0, '0, 1'b0, 1'b0);
      add_row('0, '0, '0, 1'b0, 1'b1);
      add_row(5 * ONE_Q16, '0, '0, 1'b1, 1'b0);        // zero coupling
      add_row(-3 * ONE_Q16, VAL_MAX, VAL_MIN, 1'b1, 1'b0);
      add_row('0, '0, '0, 1'b1, 1'b0);
      add_row('0, '0, '0, 1'b1, 1'b0);
      add_row(VAL_MIN, VAL_MIN, VAL_MIN, 1'b1, 1'b0);  // widest products
      add_row(VAL_MIN, '0, '0, 1'b1, 1'b0);
      add_row(VAL_MAX, VAL_MAX, '0, 1'b1, 1'b0);       // a*c equals |b|^2
      add_row(VAL_MAX, '0, '0, 1'b0, 1'b0);            // closes without its flag
      add_row(2 * ONE_Q16, '0, ONE_Q16, 1'b1, 1'b0);
      add_row(3 * ONE_Q16, '0, '0, 1'b1, 1'b0);
      add_row(-4, 1, 1, 1'b1, 1'b0);                   // negative product
      add_row(9, '0, '0, 1'b1, 1'b0);
      add_row(-7, 5, 5, 1'b1, 1'b1);                   // pair start on last row
      add_row(1, 2, '0, 1'b1, 1'b0);
      add_row(1, '0, '0, 1'b1, 1'b1);                  // pair closes on last row
      add_row('0, '0, '0, 1'b0, 1'b1);
      add_row(-1, '0, '0, 1'b0, 1'b1);
      add_row(1, '0, '0, 1'b1, 1'b1);
      wait_drained();

      // One long matrix of positive rows, then a pair and a negative last row.
      for (int k = 0; k < LONG_ROWS; k++)
         add_row(1, '0, '0, 1'b0, 1'b0);
      add_row(1, 1, '0, 1'b1, 1'b0);
      add_row(5, '0, '0, 1'b1, 1'b0);
      add_row(-1, '0, '0, 1'b0, 1'b1);
      wait_drained();

      run_random_phase(0, 0);
      run_random_phase(48, 0);
      run_random_phase(0, 48);
      run_random_phase(18, 18);

      repeat (10) @(posedge clock);
      if (mismatches == 0)
         $display("[block_diagonal_inertia_counter_unit] OK");
      else
         $display("[block_diagonal_inertia_counter_unit] ERROR");
      $finish;
   end

endmodule

>>> sim.f
+incdir+rtl/core
rtl/core/bdic_pkg.sv
rtl/core/bdic_front.sv
rtl/core/bdic_queue.sv
rtl/core/bdic_back.sv
rtl/core/block_diagonal_inertia_counter_unit.sv
bench/tb_block_diagonal_inertia_counter_unit.sv
